// ----- hdl/kwb_pkg.sv -----
// kwb_pkg: shared types, constants and codes for the k-weighting biquad cascade
// used by kwb_coef, kwb_ctrl, kwb_dp and k_weighting_biquad_cascade; no dependencies
package kwb_pkg;

  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned INNER_BITS     = SAMPLE_BITS + 4;
  localparam int unsigned COEF_BITS      = 32;
  localparam int unsigned COEF_FRAC_BITS = 28;
  localparam int unsigned PROD_BITS      = INNER_BITS + COEF_BITS;
  localparam int unsigned ACC_BITS       = 64;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned NUM_TAPS       = 5;
  localparam int unsigned TAP_BITS       = 3;

  localparam logic [TAP_BITS-1:0] LAST_TAP = TAP_BITS'(NUM_TAPS - 1);

  // round half up before the arithmetic shift
  localparam logic signed [ACC_BITS-1:0] ACC_ROUND = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] INNER_MAX = (64'sd1 <<< (INNER_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_BITS-1:0] INNER_MIN = -(64'sd1 <<< (INNER_BITS - 1));

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // coefficient defaults for 48 kHz
  localparam logic signed [COEF_BITS-1:0] RST_SHELF_B0 = 32'sd412081942;
  localparam logic signed [COEF_BITS-1:0] RST_SHELF_B1 = -32'sd722546694;
  localparam logic signed [COEF_BITS-1:0] RST_SHELF_B2 = 32'sd321691120;
  localparam logic signed [COEF_BITS-1:0] RST_SHELF_A1 = -32'sd453832899;
  localparam logic signed [COEF_BITS-1:0] RST_SHELF_A2 = 32'sd196623811;
  localparam logic signed [COEF_BITS-1:0] RST_HP_GAIN  = 32'sd267101332;
  localparam logic signed [COEF_BITS-1:0] RST_HP_A1    = -32'sd534199296;
  localparam logic signed [COEF_BITS-1:0] RST_HP_A2    = 32'sd265770496;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SHELF_B0 = 3'd0,
    REG_SHELF_B1 = 3'd1,
    REG_SHELF_B2 = 3'd2,
    REG_SHELF_A1 = 3'd3,
    REG_SHELF_A2 = 3'd4,
    REG_HP_GAIN  = 3'd5,
    REG_HP_A1    = 3'd6,
    REG_HP_A2    = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef enum logic {
    STG_SHELF,
    STG_HP
  } stage_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_SUB2
  } op_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;
  } out_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] shelf_b0;
    logic signed [COEF_BITS-1:0] shelf_b1;
    logic signed [COEF_BITS-1:0] shelf_b2;
    logic signed [COEF_BITS-1:0] shelf_a1;
    logic signed [COEF_BITS-1:0] shelf_a2;
    logic signed [COEF_BITS-1:0] hp_gain;
    logic signed [COEF_BITS-1:0] hp_a1;
    logic signed [COEF_BITS-1:0] hp_a2;
  } coef_t;

  typedef struct packed {
    logic                load_in;
    logic                mul_en;
    stage_e              stage;
    logic [TAP_BITS-1:0] tap;
    logic                acc_init;
    logic                acc_en;
    logic                load_y;
    logic                commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/kwb_coef.sv -----
// kwb_coef: coefficient register file written through the plain config port
// depends on kwb_pkg
module kwb_coef (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kwb_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [kwb_pkg::COEF_BITS-1:0]     cfg_data_i,
  output kwb_pkg::coef_t                    coef_o
);

  kwb_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.shelf_b0 <= kwb_pkg::RST_SHELF_B0;
      coef_q.shelf_b1 <= kwb_pkg::RST_SHELF_B1;
      coef_q.shelf_b2 <= kwb_pkg::RST_SHELF_B2;
      coef_q.shelf_a1 <= kwb_pkg::RST_SHELF_A1;
      coef_q.shelf_a2 <= kwb_pkg::RST_SHELF_A2;
      coef_q.hp_gain  <= kwb_pkg::RST_HP_GAIN;
      coef_q.hp_a1    <= kwb_pkg::RST_HP_A1;
      coef_q.hp_a2    <= kwb_pkg::RST_HP_A2;
    end else if (cfg_we_i) begin
      case (kwb_pkg::reg_e'(cfg_idx_i))
        kwb_pkg::REG_SHELF_B0: coef_q.shelf_b0 <= cfg_data_i;
        kwb_pkg::REG_SHELF_B1: coef_q.shelf_b1 <= cfg_data_i;
        kwb_pkg::REG_SHELF_B2: coef_q.shelf_b2 <= cfg_data_i;
        kwb_pkg::REG_SHELF_A1: coef_q.shelf_a1 <= cfg_data_i;
        kwb_pkg::REG_SHELF_A2: coef_q.shelf_a2 <= cfg_data_i;
        kwb_pkg::REG_HP_GAIN:  coef_q.hp_gain  <= cfg_data_i;
        kwb_pkg::REG_HP_A1:    coef_q.hp_a1    <= cfg_data_i;
        kwb_pkg::REG_HP_A2:    coef_q.hp_a2    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

// ----- hdl/kwb_ctrl.sv -----
// kwb_ctrl: sequencer that steps the shared multiply-accumulate through both biquads
// depends on kwb_pkg
module kwb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kwb_pkg::sts_t  sts_i,
  output kwb_pkg::cmd_t  cmd_o
);

  kwb_pkg::state_e              state_q, state_d;
  kwb_pkg::stage_e              stage_q, stage_d;
  logic [kwb_pkg::TAP_BITS-1:0] tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwb_pkg::ST_IDLE;
      stage_q <= kwb_pkg::STG_SHELF;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      tap_q   <= tap_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    stage_d      = stage_q;
    tap_d        = tap_q;
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    cmd_o.stage  = stage_q;
    cmd_o.tap    = tap_q;
    case (state_q)
      kwb_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          stage_d       = kwb_pkg::STG_SHELF;
          tap_d         = '0;
          state_d       = kwb_pkg::ST_MAC;
        end
      end
      kwb_pkg::ST_MAC: begin
        // multiply this tap, accumulate the previous product
        cmd_o.mul_en   = 1'b1;
        cmd_o.acc_init = (tap_q == '0);
        cmd_o.acc_en   = (tap_q != '0);
        tap_d          = tap_q + 1'b1;
        if (tap_q == kwb_pkg::LAST_TAP) begin
          state_d = kwb_pkg::ST_DRAIN;
        end
      end
      kwb_pkg::ST_DRAIN: begin
        cmd_o.acc_en = 1'b1;
        state_d      = kwb_pkg::ST_FIN;
      end
      kwb_pkg::ST_FIN: begin
        if (stage_q == kwb_pkg::STG_SHELF) begin
          cmd_o.load_y = 1'b1;
          stage_d      = kwb_pkg::STG_HP;
          tap_d        = '0;
          state_d      = kwb_pkg::ST_MAC;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = kwb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kwb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/kwb_dp.sv -----
// kwb_dp: shared multiplier, accumulator, round/saturate, filter history and output register
// depends on kwb_pkg
module kwb_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kwb_pkg::cmd_t   cmd_i,
  output kwb_pkg::sts_t   sts_o,
  input  kwb_pkg::coef_t  coef_i,
  input  kwb_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output kwb_pkg::out_t   out_data_o
);

  localparam int unsigned HEAD = kwb_pkg::INNER_BITS - kwb_pkg::SAMPLE_BITS;
  localparam int unsigned PEXT = kwb_pkg::ACC_BITS - kwb_pkg::PROD_BITS;

  logic signed [kwb_pkg::SAMPLE_BITS-1:0] x_q;
  logic                                   be_q;
  logic signed [kwb_pkg::SAMPLE_BITS-1:0] sih0_q, sih1_q;
  logic signed [kwb_pkg::INNER_BITS-1:0]  soh0_q, soh1_q;
  logic signed [kwb_pkg::INNER_BITS-1:0]  hoh0_q, hoh1_q;
  logic signed [kwb_pkg::INNER_BITS-1:0]  y_q;

  logic signed [kwb_pkg::INNER_BITS-1:0]  mul_a;
  logic signed [kwb_pkg::COEF_BITS-1:0]   mul_b;
  kwb_pkg::op_e                           mul_op;
  logic signed [kwb_pkg::PROD_BITS-1:0]   prod_d, prod_q;
  kwb_pkg::op_e                           prod_op_q;
  logic signed [kwb_pkg::ACC_BITS-1:0]    prod_ext, acc_d, acc_q, acc_sh;
  logic signed [kwb_pkg::INNER_BITS-1:0]  fin_val;
  logic signed [kwb_pkg::SAMPLE_BITS-1:0] out_sample;

  logic          out_valid_q;
  kwb_pkg::out_t out_data_q;

  // operand and sign selection per stage and tap
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_op = kwb_pkg::OP_ADD;
    if (cmd_i.stage == kwb_pkg::STG_SHELF) begin
      case (cmd_i.tap)
        3'd0: begin
          mul_a = {{HEAD{x_q[kwb_pkg::SAMPLE_BITS-1]}}, x_q};
          mul_b = coef_i.shelf_b0;
        end
        3'd1: begin
          mul_a = {{HEAD{sih0_q[kwb_pkg::SAMPLE_BITS-1]}}, sih0_q};
          mul_b = coef_i.shelf_b1;
        end
        3'd2: begin
          mul_a = {{HEAD{sih1_q[kwb_pkg::SAMPLE_BITS-1]}}, sih1_q};
          mul_b = coef_i.shelf_b2;
        end
        3'd3: begin
          mul_a  = soh0_q;
          mul_b  = coef_i.shelf_a1;
          mul_op = kwb_pkg::OP_SUB;
        end
        3'd4: begin
          mul_a  = soh1_q;
          mul_b  = coef_i.shelf_a2;
          mul_op = kwb_pkg::OP_SUB;
        end
        default: ;
      endcase
    end else begin
      case (cmd_i.tap)
        3'd0: begin
          mul_a = y_q;
          mul_b = coef_i.hp_gain;
        end
        3'd1: begin
          // middle highpass tap is -2 * gain
          mul_a  = soh0_q;
          mul_b  = coef_i.hp_gain;
          mul_op = kwb_pkg::OP_SUB2;
        end
        3'd2: begin
          mul_a = soh1_q;
          mul_b = coef_i.hp_gain;
        end
        3'd3: begin
          mul_a  = hoh0_q;
          mul_b  = coef_i.hp_a1;
          mul_op = kwb_pkg::OP_SUB;
        end
        3'd4: begin
          mul_a  = hoh1_q;
          mul_b  = coef_i.hp_a2;
          mul_op = kwb_pkg::OP_SUB;
        end
        default: ;
      endcase
    end
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {{PEXT{prod_q[kwb_pkg::PROD_BITS-1]}}, prod_q};

  always_comb begin
    case (prod_op_q)
      kwb_pkg::OP_ADD:  acc_d = acc_q + prod_ext;
      kwb_pkg::OP_SUB:  acc_d = acc_q - prod_ext;
      kwb_pkg::OP_SUB2: acc_d = acc_q - (prod_ext <<< 1);
      default:          acc_d = acc_q;
    endcase
  end

  // accumulator starts at the rounding offset, so finishing is shift and clamp
  assign acc_sh = acc_q >>> kwb_pkg::COEF_FRAC_BITS;

  always_comb begin
    if (acc_sh > kwb_pkg::INNER_MAX) begin
      fin_val = kwb_pkg::INNER_BITS'(kwb_pkg::INNER_MAX);
    end else if (acc_sh < kwb_pkg::INNER_MIN) begin
      fin_val = kwb_pkg::INNER_BITS'(kwb_pkg::INNER_MIN);
    end else begin
      fin_val = acc_sh[kwb_pkg::INNER_BITS-1:0];
    end
  end

  always_comb begin
    if (fin_val[kwb_pkg::INNER_BITS-1:kwb_pkg::SAMPLE_BITS-1] == '0 ||
        fin_val[kwb_pkg::INNER_BITS-1:kwb_pkg::SAMPLE_BITS-1] == '1) begin
      out_sample = fin_val[kwb_pkg::SAMPLE_BITS-1:0];
    end else if (fin_val[kwb_pkg::INNER_BITS-1]) begin
      out_sample = kwb_pkg::SAMPLE_MIN;
    end else begin
      out_sample = kwb_pkg::SAMPLE_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q  <= in_data_i.sample_in;
      be_q <= in_data_i.block_end;
    end
    if (cmd_i.mul_en) begin
      prod_q    <= prod_d;
      prod_op_q <= mul_op;
    end
    if (cmd_i.acc_init) begin
      acc_q <= kwb_pkg::ACC_ROUND;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.load_y) begin
      y_q <= fin_val;
    end
    if (cmd_i.commit) begin
      out_data_q.sample_out    <= out_sample;
      out_data_q.block_end_out <= be_q;
    end
  end

  // filter history and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sih0_q      <= '0;
      sih1_q      <= '0;
      soh0_q      <= '0;
      soh1_q      <= '0;
      hoh0_q      <= '0;
      hoh1_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        sih1_q <= sih0_q;
        sih0_q <= x_q;
        soh1_q <= soh0_q;
        soh0_q <= y_q;
        hoh1_q <= hoh0_q;
        hoh0_q <= fin_val;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

// ----- hdl/k_weighting_biquad_cascade.sv -----
// Loudness (K) weighting filter: a high-shelf biquad followed by a second-order
// highpass, both direct form I with signed Q3.28 coefficients and 28-bit output
// history. One sample goes in, one weighted 24-bit saturated sample comes out,
// with the block-end flag copied along. A single 28x32 multiplier does all ten
// products in turn: after the accept step, each biquad takes five multiplies, one
// accumulate and one round/saturate, and the last round/saturate step loads the
// result into the output register. A new sample is taken only while the
// sequencer is idle; a finished result may wait in the output register while the
// next sample is taken, and a stalled output holds the sequencer in its last
// round/saturate step. The user must write coefficients through the config port
// only while no sample is in flight; the block itself does not enforce it.
// depends on kwb_pkg, kwb_coef, kwb_ctrl, kwb_dp
module k_weighting_biquad_cascade (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  kwb_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output kwb_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [kwb_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [kwb_pkg::COEF_BITS-1:0]     cfg_data_i
);

  kwb_pkg::coef_t coef;
  kwb_pkg::cmd_t  cmd;
  kwb_pkg::sts_t  sts;

  kwb_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  kwb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kwb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .coef_i      (coef),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
